### rtl/cop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cop_pkg
// Shared constants for the circle octant point generator: field widths,
// configuration register indexes and the fixed-point step end ratio.
// ----------------------------------------------------------------------------
package cop_pkg;

    // field widths fixed by the interface
    localparam int unsigned COORD_IN_W = 10;
    localparam int unsigned POINT_W    = 11;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned SCREEN_W   = 10;
    localparam int unsigned PORT_R_W   = 8;

    // step end ratio 0.7071 as an exact fraction
    localparam int unsigned FIX_NUM = 7071;
    localparam int unsigned FIX_DEN = 10000;
    localparam int unsigned FIX_W   = 14;

    // points per item
    localparam int unsigned NUM_POINTS = 8;
    localparam int unsigned POINT_IDX_W = 3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // register reset values
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 10'd127;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 10'd159;

endpackage

### rtl/cop_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cop_queue
// Two-entry queue between the root front end and the point emitter.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cop_queue #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [0:1];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         w_push;
    logic         w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push & o_ready;
    assign w_pop   = i_pop & o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/cop_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cop_front
// Accepts items, squares radius and offset, takes the integer square root
// of their difference two digits a cycle and flags the step end.
// ----------------------------------------------------------------------------
module cop_front
    import cop_pkg::*;
#(
    parameter int unsigned RADIUS_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [COORD_IN_W-1:0] i_center_x,
    input  logic [COORD_IN_W-1:0] i_center_y,
    input  logic [PORT_R_W-1:0]   i_radius,
    input  logic [PORT_R_W-1:0]   i_step_offset,
    input  logic [COLOR_W-1:0]    i_pixel_color,
    output logic                  o_push,
    input  logic                  i_q_ready,
    output logic [1+COLOR_W+2*COORD_IN_W+2*RADIUS_BITS-1:0] o_q_data
);

    localparam int unsigned RB  = RADIUS_BITS;
    localparam int unsigned SQ  = (RB + 1) / 2;   // root steps, two digits each
    localparam int unsigned NW  = 4 * SQ;         // radicand width
    localparam int unsigned TW  = 2 * SQ;         // root width
    localparam int unsigned RW  = 2 * SQ + 3;     // partial remainder width
    localparam int unsigned CNW = (SQ > 1) ? $clog2(SQ) : 1;
    localparam int unsigned FW  = RB + FIX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_ROOT,
        S_PUSH
    } t_state;

    t_state                r_state;
    logic [CNW-1:0]        r_cnt;
    logic [2*RB-1:0]       r_rr;
    logic [2*RB-1:0]       r_xx;
    logic [RB-1:0]         r_r;
    logic [RB-1:0]         r_x;
    logic [COORD_IN_W-1:0] r_cx;
    logic [COORD_IN_W-1:0] r_cy;
    logic [COLOR_W-1:0]    r_color;
    logic                  r_fin;
    logic [NW-1:0]         r_num;
    logic [RW-1:0]         r_rem;
    logic [TW-1:0]         r_root;

    logic [RB-1:0]         w_r;
    logic [RB-1:0]         w_x;
    logic                  w_accept;
    logic [FW-1:0]         w_prod;
    logic [FW-1:0]         w_hi;
    logic [FW-1:0]         w_lo;
    logic                  w_fin;
    logic [RW-1:0]         w_rem  [0:2];
    logic [TW-1:0]         w_root [0:2];
    logic [RW-1:0]         w_sh   [0:1];
    logic [RW-1:0]         w_trial[0:1];

    // radius and offset limited to the configured radius width
    generate
        if (RB <= PORT_R_W) begin : g_narrow
            assign w_r = i_radius[RB-1:0];
            assign w_x = i_step_offset[RB-1:0];
        end else begin : g_wide
            assign w_r = {{(RB-PORT_R_W){1'b0}}, i_radius};
            assign w_x = {{(RB-PORT_R_W){1'b0}}, i_step_offset};
        end
    endgenerate

    // ready while idle or while handing the last item over
    assign o_busy   = !((r_state == S_IDLE) || ((r_state == S_PUSH) && i_q_ready));
    assign w_accept = i_start & ~o_busy;
    assign o_push   = (r_state == S_PUSH);
    assign o_q_data = {r_fin, r_color, r_cx, r_cy, r_x, r_root[RB-1:0]};

    // step end test: x - 1 == floor(7071 r / 10000)
    always_comb begin
        w_prod = FW'(r_r) * FW'(FIX_NUM);
        w_hi   = FW'(r_x) * FW'(FIX_DEN);
        w_lo   = w_hi - FW'(FIX_DEN);
        w_fin  = (r_x != '0) && (w_lo <= w_prod) && (w_prod < w_hi);
    end

    // two digits of the restoring square root
    always_comb begin
        w_rem[0]  = r_rem;
        w_root[0] = r_root;
        for (int j = 0; j < 2; j++) begin
            w_sh[j]    = {w_rem[j][RW-3:0], r_num[NW-1-2*j -: 2]};
            w_trial[j] = RW'({w_root[j], 2'b01});
            if (w_sh[j] >= w_trial[j]) begin
                w_rem[j+1]  = w_sh[j] - w_trial[j];
                w_root[j+1] = {w_root[j][TW-2:0], 1'b1};
            end else begin
                w_rem[j+1]  = w_sh[j];
                w_root[j+1] = {w_root[j][TW-2:0], 1'b0};
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_cnt   <= CNW'(SQ - 1);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_cnt == '0) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_cnt <= r_cnt - CNW'(1);
                    end
                end
                S_PUSH: begin
                    if (i_q_ready) begin
                        r_state <= w_accept ? S_DIFF : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item capture and squares
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rr    <= (2*RB)'(w_r) * (2*RB)'(w_r);
            r_xx    <= (2*RB)'(w_x) * (2*RB)'(w_x);
            r_r     <= w_r;
            r_x     <= w_x;
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_color <= i_pixel_color;
        end
    end

    // radicand, root and step end flag
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIFF) begin
            r_num  <= (r_rr >= r_xx) ? NW'(r_rr - r_xx) : '0;
            r_rem  <= '0;
            r_root <= '0;
            r_fin  <= w_fin;
        end else if (r_state == S_ROOT) begin
            r_num  <= {r_num[NW-5:0], 4'b0000};
            r_rem  <= w_rem[2];
            r_root <= w_root[2];
        end
    end

endmodule

### rtl/cop_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cop_back
// Emits the eight symmetric points of the item at the queue head, one per
// cycle, with screen clipping, into registered outputs.
// ----------------------------------------------------------------------------
module cop_back
    import cop_pkg::*;
#(
    parameter int unsigned RADIUS_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [1+COLOR_W+2*COORD_IN_W+2*RADIUS_BITS-1:0] i_q_data,
    output logic                  o_pop,
    input  logic [SCREEN_W-1:0]   i_screen_width,
    input  logic [SCREEN_W-1:0]   i_screen_height,
    output logic                  o_point_strobe,
    output logic [POINT_W-1:0]    o_point_x,
    output logic [POINT_W-1:0]    o_point_y,
    output logic [COLOR_W-1:0]    o_point_color,
    output logic                  o_on_screen,
    output logic                  o_last_of_step,
    output logic                  o_final_step
);

    localparam int unsigned RB = RADIUS_BITS;
    localparam int unsigned CW = (RB + 2 > POINT_W) ? RB + 2 : POINT_W;
    localparam int unsigned Y_LO  = 0;
    localparam int unsigned X_LO  = RB;
    localparam int unsigned CY_LO = 2 * RB;
    localparam int unsigned CX_LO = CY_LO + COORD_IN_W;
    localparam int unsigned CL_LO = CX_LO + COORD_IN_W;
    localparam int unsigned FN_LO = CL_LO + COLOR_W;

    logic [POINT_IDX_W-1:0] r_k;
    logic                   r_strobe;
    logic [POINT_W-1:0]     r_px;
    logic [POINT_W-1:0]     r_py;
    logic [COLOR_W-1:0]     r_color;
    logic                   r_on;
    logic                   r_last;
    logic                   r_fin;

    logic [RB-1:0]          w_x;
    logic [RB-1:0]          w_y;
    logic [COORD_IN_W-1:0]  w_cx;
    logic [COORD_IN_W-1:0]  w_cy;
    logic [CW-1:0]          w_dx;
    logic [CW-1:0]          w_dy;
    logic [CW-1:0]          w_ecx;
    logic [CW-1:0]          w_ecy;
    logic [CW-1:0]          w_px;
    logic [CW-1:0]          w_py;
    logic                   w_on;

    // unpack queue head
    assign w_y  = i_q_data[Y_LO +: RB];
    assign w_x  = i_q_data[X_LO +: RB];
    assign w_cy = i_q_data[CY_LO +: COORD_IN_W];
    assign w_cx = i_q_data[CX_LO +: COORD_IN_W];

    assign o_pop = i_q_valid && (r_k == POINT_IDX_W'(NUM_POINTS - 1));

    // point k: bit 2 swaps x and y, bit 1 negates column, bit 0 negates row
    always_comb begin
        w_ecx = {{(CW-COORD_IN_W){w_cx[COORD_IN_W-1]}}, w_cx};
        w_ecy = {{(CW-COORD_IN_W){w_cy[COORD_IN_W-1]}}, w_cy};
        w_dx  = r_k[2] ? CW'(w_y) : CW'(w_x);
        w_dy  = r_k[2] ? CW'(w_x) : CW'(w_y);
        w_px  = r_k[1] ? (w_ecx - w_dx) : (w_ecx + w_dx);
        w_py  = r_k[0] ? (w_ecy - w_dy) : (w_ecy + w_dy);
        w_on  = !w_px[CW-1] && (w_px < CW'(i_screen_width)) &&
                !w_py[CW-1] && (w_py < CW'(i_screen_height));
    end

    // point counter and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_q_valid;
            if (i_q_valid) begin
                r_k <= r_k + POINT_IDX_W'(1);
            end
        end
    end

    // output registers
    always_ff @(posedge i_clk) begin
        if (i_q_valid) begin
            r_px    <= w_px[POINT_W-1:0];
            r_py    <= w_py[POINT_W-1:0];
            r_color <= i_q_data[CL_LO +: COLOR_W];
            r_on    <= w_on;
            r_last  <= (r_k == POINT_IDX_W'(NUM_POINTS - 1));
            r_fin   <= i_q_data[FN_LO];
        end
    end

    assign o_point_strobe = r_strobe;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_point_color  = r_color;
    assign o_on_screen    = r_on;
    assign o_last_of_step = r_last;
    assign o_final_step   = r_fin;

endmodule

### rtl/circle_octant_point_generator.sv
`timescale 1ns / 1ps
// Path: an accepted item passes the difference, root and push states of the
// front end, then the queue, then the registered outputs of the point emitter.
// Flow: the point emitter sends one point a cycle while the queue holds an item,
// and the front end can take the next item while earlier ones are still emitted.
// Reset: synchronous active low; clears control state and loads width 127 and
// height 159. The receiver cannot stall; each point is valid for one cycle.
// ----------------------------------------------------------------------------
// circle_octant_point_generator
// Turns one circle step into its eight symmetric points with screen clipping;
// holds the screen size registers and joins front end, queue and emitter.
// ----------------------------------------------------------------------------
module circle_octant_point_generator
    import cop_pkg::*;
#(
    parameter int unsigned RADIUS_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_IN_W-1:0] i_center_x,
    input  logic [COORD_IN_W-1:0] i_center_y,
    input  logic [PORT_R_W-1:0]   i_radius,
    input  logic [PORT_R_W-1:0]   i_step_offset,
    input  logic [COLOR_W-1:0]    i_pixel_color,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SCREEN_W-1:0]   i_cfg_data,
    output logic                  o_point_strobe,
    output logic [POINT_W-1:0]    o_point_x,
    output logic [POINT_W-1:0]    o_point_y,
    output logic [COLOR_W-1:0]    o_point_color,
    output logic                  o_on_screen,
    output logic                  o_last_of_step,
    output logic                  o_final_step
);

    localparam int unsigned QW = 1 + COLOR_W + 2 * COORD_IN_W + 2 * RADIUS_BITS;

    logic [SCREEN_W-1:0] r_screen_width;
    logic [SCREEN_W-1:0] r_screen_height;
    logic                w_push;
    logic                w_q_ready;
    logic [QW-1:0]       w_push_data;
    logic                w_pop;
    logic                w_q_valid;
    logic [QW-1:0]       w_head_data;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SCREEN_WIDTH) begin
                r_screen_width <= i_cfg_data;
            end else if (i_cfg_index == REG_SCREEN_HEIGHT) begin
                r_screen_height <= i_cfg_data;
            end
        end
    end

    // square root front end
    cop_front #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_step_offset (i_step_offset),
        .i_pixel_color (i_pixel_color),
        .o_push        (w_push),
        .i_q_ready     (w_q_ready),
        .o_q_data      (w_push_data)
    );

    // item queue
    cop_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head_data)
    );

    // point emitter
    cop_back #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_data        (w_head_data),
        .o_pop           (w_pop),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_point_strobe  (o_point_strobe),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_point_color   (o_point_color),
        .o_on_screen     (o_on_screen),
        .o_last_of_step  (o_last_of_step),
        .o_final_step    (o_final_step)
    );

endmodule

### verif/circle_octant_point_generator_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_octant_point_generator_check
// Watches the step, configuration and point channels of the circle octant
// point generator. Keeps its own copy of the screen size registers, works out
// the eight points due for every accepted item and compares each point strobe
// field by field with the oldest point still due.
// ----------------------------------------------------------------------------
module circle_octant_point_generator_check
    import cop_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [COORD_IN_W-1:0] i_center_x,
    input  logic [COORD_IN_W-1:0] i_center_y,
    input  logic [PORT_R_W-1:0]   i_radius,
    input  logic [PORT_R_W-1:0]   i_step_offset,
    input  logic [COLOR_W-1:0]    i_pixel_color,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SCREEN_W-1:0]   i_cfg_data,
    input  logic                  i_point_strobe,
    input  logic [POINT_W-1:0]    i_point_x,
    input  logic [POINT_W-1:0]    i_point_y,
    input  logic [COLOR_W-1:0]    i_point_color,
    input  logic                  i_on_screen,
    input  logic                  i_last_of_step,
    input  logic                  i_final_step,
    output int                    o_pending,
    output int                    o_fail_count
);

    // one symmetric point as it should leave the block
    typedef struct packed {
        logic [POINT_W-1:0] col;
        logic [POINT_W-1:0] row;
        logic [COLOR_W-1:0] color;
        logic               on_scr;
        logic               last_pt;
        logic               fin;
    } t_point;

    logic [SCREEN_W-1:0] width_reg;
    logic [SCREEN_W-1:0] height_reg;
    t_point              points_due[$];
    int                  fail_total  = 0;
    int                  points_seen = 0;

    // largest root whose square does not exceed n, one bit at a time
    function automatic int unsigned floor_root(input int unsigned n);
        int unsigned root;
        int unsigned trial;
        int          b;
        root = 0;
        for (b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (longint'(trial) * longint'(trial) <= longint'(n)) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: point %0d %s: got 0x%0h, expected 0x%0h",
                 $time, points_seen, what, got, want);
        fail_total++;
    endtask

    // eight points of one item in the fixed octant order
    task automatic predict_step();
        int          cx;
        int          cy;
        int          ox;
        int          oy;
        int          dx;
        int          dy;
        int          px;
        int          py;
        int          k;
        int unsigned rr;
        int unsigned xx;
        int unsigned step_end;
        t_point      p;
        cx = int'($signed(i_center_x));
        cy = int'($signed(i_center_y));
        ox = int'(i_step_offset);
        rr = 32'(i_radius) * 32'(i_radius);
        xx = 32'(i_step_offset) * 32'(i_step_offset);
        // offset beyond the radius gives a zero row offset
        oy = (rr >= xx) ? int'(floor_root(rr - xx)) : 0;
        step_end = (FIX_NUM * 32'(i_radius)) / FIX_DEN + 32'd1;
        for (k = 0; k < NUM_POINTS; k++) begin
            // second half of the octants swaps the roles of x and y
            dx = (k < 4) ? ox : oy;
            dy = (k < 4) ? oy : ox;
            px = cx + (k[1] ? -dx : dx);
            py = cy + (k[0] ? -dy : dy);
            p.col     = px[POINT_W-1:0];
            p.row     = py[POINT_W-1:0];
            p.color   = i_pixel_color;
            p.on_scr  = (px >= 0) && (px < int'(width_reg)) &&
                        (py >= 0) && (py < int'(height_reg));
            p.last_pt = (k == NUM_POINTS - 1);
            p.fin     = (ox == int'(step_end));
            points_due.push_back(p);
        end
    endtask

    // compare one strobed point with the oldest point due
    task automatic check_point();
        t_point want;
        points_seen++;
        if (points_due.size() == 0) begin
            report_mismatch("strobe with no point due", 32'd1, 32'd0);
            return;
        end
        want = points_due.pop_front();
        if (i_point_x !== want.col)          report_mismatch("point_x", 32'(i_point_x),
                                                             32'(want.col));
        if (i_point_y !== want.row)          report_mismatch("point_y", 32'(i_point_y),
                                                             32'(want.row));
        if (i_point_color !== want.color)    report_mismatch("point_color",
                                                             32'(i_point_color),
                                                             32'(want.color));
        if (i_on_screen !== want.on_scr)     report_mismatch("on_screen", 32'(i_on_screen),
                                                             32'(want.on_scr));
        if (i_last_of_step !== want.last_pt) report_mismatch("last_of_step",
                                                             32'(i_last_of_step),
                                                             32'(want.last_pt));
        if (i_final_step !== want.fin)       report_mismatch("final_step", 32'(i_final_step),
                                                             32'(want.fin));
    endtask

    // watch all channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            points_due.delete();
        end else begin
            if (i_point_strobe !== 1'b0) begin
                check_point();
            end
            // writes to an unknown index leave both registers alone
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  = i_cfg_data;
                    REG_SCREEN_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                predict_step();
            end
        end
        o_pending    <= points_due.size();
        o_fail_count <= fail_total;
    end

endmodule

### verif/circle_octant_point_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_octant_point_generator_test
// Drives circle steps and screen size writes into the point generator: a
// directed set of edge cases, then random phases of circle walks mixed
// with noise items, each phase under its own screen size. A separate checker
// predicts and compares every point; this module gives the verdict.
// ----------------------------------------------------------------------------
module circle_octant_point_generator_test;
    import cop_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int RANDOM_ITEMS = 290;
    localparam int TAIL_CYCLES  = 32;
    localparam int LIMIT_CYCLES = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [COORD_IN_W-1:0] i_center_x;
    logic [COORD_IN_W-1:0] i_center_y;
    logic [PORT_R_W-1:0]   i_radius;
    logic [PORT_R_W-1:0]   i_step_offset;
    logic [COLOR_W-1:0]    i_pixel_color;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [SCREEN_W-1:0]   i_cfg_data;
    logic                  o_point_strobe;
    logic [POINT_W-1:0]    o_point_x;
    logic [POINT_W-1:0]    o_point_y;
    logic [COLOR_W-1:0]    o_point_color;
    logic                  o_on_screen;
    logic                  o_last_of_step;
    logic                  o_final_step;
    int                    pending;
    int                    fail_count;

    int cycle_count = 0;
    int items_sent  = 0;
    int pause_at    = 0;
    bit burst       = 1'b0;

    circle_octant_point_generator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_step_offset  (i_step_offset),
        .i_pixel_color  (i_pixel_color),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_point_strobe (o_point_strobe),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_color  (o_point_color),
        .o_on_screen    (o_on_screen),
        .o_last_of_step (o_last_of_step),
        .o_final_step   (o_final_step)
    );

    circle_octant_point_generator_check point_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_step_offset  (i_step_offset),
        .i_pixel_color  (i_pixel_color),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_point_strobe (o_point_strobe),
        .i_point_x      (o_point_x),
        .i_point_y      (o_point_y),
        .i_point_color  (o_point_color),
        .i_on_screen    (o_on_screen),
        .i_last_of_step (o_last_of_step),
        .i_final_step   (o_final_step),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sender stops and waits until every point due has left
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    // one item, after a random gap unless in a burst stretch
    task automatic send_step(input int cx, input int cy, input int r, input int x,
                             input int color);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_center_x    <= cx[COORD_IN_W-1:0];
        i_center_y    <= cy[COORD_IN_W-1:0];
        i_radius      <= r[PORT_R_W-1:0];
        i_step_offset <= x[PORT_R_W-1:0];
        i_pixel_color <= color[COLOR_W-1:0];
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (items_sent == pause_at) begin
            wait_drained();
        end
    endtask

    // screen size writes while idle, optionally one to an unused index
    task automatic configure(input int w, input int h, input bit spare,
                             input logic [CFG_IDX_W-1:0] spare_idx);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SCREEN_WIDTH;
        i_cfg_data  <= w[SCREEN_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_SCREEN_HEIGHT;
        i_cfg_data  <= h[SCREEN_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (spare) begin
            i_cfg_index <= spare_idx;
            i_cfg_data  <= SCREEN_W'($urandom_range(0, 1023));
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // screen extent for a random phase, extremes weighted in
    function automatic int pick_extent();
        case ($urandom_range(0, 5))
            0:       return 1023;
            1:       return 1;
            2:       return $urandom_range(1, 64);
            default: return $urandom_range(64, 1023);
        endcase
    endfunction

    initial begin
        int phase_end;
        int r;
        int x;
        int x_end;
        int cx;
        int cy;
        int color;

        start         <= 1'b0;
        i_center_x    <= '0;
        i_center_y    <= '0;
        i_radius      <= '0;
        i_step_offset <= '0;
        i_pixel_color <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_SCREEN_WIDTH;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items under the reset screen size
        send_step(10, 10, 0, 0, 'h123456);          // radius zero
        send_step(10, 10, 0, 1, 'h654321);          // radius zero at its step end
        send_step(60, 80, 5, 3, 'h00ff00);
        send_step(60, 80, 10, 8, 'h0000ff);         // step end of a small circle
        send_step(64, 64, 1, 255, 'haaaaaa);        // offset beyond radius
        send_step(0, 0, 255, 0, 'h000000);
        send_step(0, 0, 255, 181, 'hffffff);        // step end of the largest circle
        send_step(0, 0, 255, 255, 'h555555);        // offset equal to radius
        send_step(-512, -512, 255, 255, 'h0f0f0f);  // most negative points
        send_step(511, 511, 255, 255, 'hf0f0f0);    // most positive points
        send_step(511, -512, 128, 200, 'h800001);
        send_step(-1, -1, 100, 71, 'h7ffffe);
        send_step(126, 158, 1, 0, 'h112233);        // straddles the right and bottom edge
        send_step(127, 159, 3, 0, 'h332211);

        // zero width, then zero height: every point clipped
        configure(0, 1023, 1'b1, REG_SPARE_LO);
        send_step(5, 5, 2, 1, 'h010203);
        send_step(0, 0, 0, 0, 'h040506);
        configure(1023, 0, 1'b1, REG_SPARE_HI);
        send_step(5, 5, 2, 1, 'h070809);
        // one pixel screen
        configure(1, 1, 1'b0, REG_SPARE_LO);
        send_step(0, 0, 0, 0, 'h0a0b0c);
        send_step(0, 1, 1, 0, 'h0d0e0f);
        // largest screen
        configure(1023, 1023, 1'b0, REG_SPARE_LO);
        send_step(511, 511, 255, 0, 'hfedcba);
        send_step(200, 300, 150, 106, 'habcdef);

        // random phases, each under its own screen size
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            configure(pick_extent(), pick_extent(), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI);
            phase_end = items_sent + $urandom_range(40, 70);
            if (phase_end > RANDOM_ITEMS) begin
                phase_end = RANDOM_ITEMS;
            end
            pause_at  = items_sent + $urandom_range(5, 35);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 3) == 0) begin
                    // noise item over the full field ranges
                    if ($urandom_range(0, 9) == 0) burst = ~burst;
                    send_step($urandom, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    // walk along one circle up to its step end
                    r = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 255)
                                                     : $urandom_range(1, 24);
                    x_end = (7071 * r) / 10000 + 1;
                    x = (r > 24) ? x_end - $urandom_range(0, 10) : 0;
                    // broken walks: overrun the end or stop short of it
                    case ($urandom_range(0, 7))
                        0:       x_end = x_end + $urandom_range(1, 3);
                        1:       x_end = x + $urandom_range(0, x_end - x);
                        default: ;
                    endcase
                    cx    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 160);
                    cy    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 160);
                    color = $urandom;
                    for (; x <= x_end; x++) begin
                        if ($urandom_range(0, 9) == 0) burst = ~burst;
                        send_step(cx, cy, r, x, color);
                    end
                end
            end
        end

        // drain and let any stray point show up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
